FILE: hdl/lbf_pkg.sv
package lbf_pkg;

  localparam int LEVEL_W = 8;
  localparam int CMD_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LED_INVERT = 3'd0,
    REG_FADE_STEP  = 3'd1,
    REG_MAX_LEVEL  = 3'd2,
    REG_MIN_LEVEL  = 3'd3,
    REG_FLASH_MODE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic   led_invert;
    level_t fade_step;
    level_t max_level;
    level_t min_level;
    logic   flash_mode;
  } cfg_t;

  localparam level_t LEVEL_FULL = level_t'(255);
  localparam level_t LEVEL_ZERO = level_t'(0);

endpackage

FILE: hdl/led_brightness_fade_ramp.sv
// LED brightness fader with a slew-limited level.
// Input channel (in_valid/in_ready): each transfer is a refresh tick
// (is_command = 0) or an on/off command (is_command = 1, command_value).
// Every transfer updates the target and steps the level toward it by
// fade_step; a duty transfer appears on the output channel
// (out_valid/out_ready) only when the level changes, and always for the
// first input after reset.
// Each duty value is registered in the output buffer before it is presented.
// Throughput: one input per cycle while in_ready is high; the level
// update is a single compare-and-step pass on the state registers.
// Configuration: cfg_wen/cfg_index/cfg_data write one register per cycle,
// with no handshake; write only while the block is idle.
// Reset (rst, synchronous) restores register defaults, zeroes the level and
// target, and arms the first-output flag.
// Receiver stall: a two-entry output buffer holds pending duty values;
// in_ready drops only when both entries are full.
module led_brightness_fade_ramp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             is_command,
  input  logic [lbf_pkg::CMD_W-1:0]        command_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lbf_pkg::LEVEL_W-1:0]      duty,
  input  logic                             cfg_wen,
  input  logic [lbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  lbf_pkg::cfg_t   cfg;
  logic            accept;
  logic            emit;
  lbf_pkg::level_t level_next;

  assign accept = in_valid && in_ready;

  lbf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lbf_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .is_command    (is_command),
    .command_value (command_value),
    .emit          (emit),
    .level_next    (level_next)
  );

  lbf_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && emit),
    .push_data  (level_next),
    .can_accept (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .duty       (duty)
  );

endmodule

FILE: hdl/lbf_cfg.sv
module lbf_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [lbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output lbf_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_invert <= 1'b0;
      cfg.fade_step  <= lbf_pkg::LEVEL_FULL;
      cfg.max_level  <= lbf_pkg::LEVEL_FULL;
      cfg.min_level  <= lbf_pkg::LEVEL_ZERO;
      cfg.flash_mode <= 1'b0;
    end else if (cfg_wen) begin
      // indexes past the register list are dropped
      unique case (cfg_index)
        lbf_pkg::REG_LED_INVERT: cfg.led_invert <= cfg_data[0];
        lbf_pkg::REG_FADE_STEP:  cfg.fade_step  <= cfg_data[lbf_pkg::LEVEL_W-1:0];
        lbf_pkg::REG_MAX_LEVEL:  cfg.max_level  <= cfg_data[lbf_pkg::LEVEL_W-1:0];
        lbf_pkg::REG_MIN_LEVEL:  cfg.min_level  <= cfg_data[lbf_pkg::LEVEL_W-1:0];
        lbf_pkg::REG_FLASH_MODE: cfg.flash_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/lbf_core.sv
module lbf_core (
  input  logic                         clk,
  input  logic                         rst,
  input  lbf_pkg::cfg_t                cfg,
  input  logic                         accept,
  input  logic                         is_command,
  input  logic [lbf_pkg::CMD_W-1:0]    command_value,
  output logic                         emit,
  output lbf_pkg::level_t              level_next
);

  lbf_pkg::level_t level;
  lbf_pkg::level_t target;
  logic            applied_valid;

  lbf_pkg::level_t target_cmd;
  lbf_pkg::level_t target_next;
  lbf_pkg::level_t diff_up;
  lbf_pkg::level_t diff_dn;

  always_comb begin
    target_cmd = target;
    if (is_command) begin
      if (command_value != {{(lbf_pkg::CMD_W-1){1'b0}}, cfg.led_invert}) begin
        target_cmd = cfg.max_level;
      end else begin
        target_cmd = cfg.min_level;
      end
    end

    // flash: bounce off the trough first, then the peak
    target_next = target_cmd;
    if (cfg.flash_mode) begin
      priority if (level <= cfg.min_level) begin
        target_next = cfg.max_level;
      end else if (level >= cfg.max_level) begin
        target_next = cfg.min_level;
      end else begin
        target_next = target_cmd;
      end
    end

    diff_up = target_next - level;
    diff_dn = level - target_next;
    level_next = level;
    if (level < target_next) begin
      level_next = (diff_up < cfg.fade_step) ? target_next : level + cfg.fade_step;
    end else if (level > target_next) begin
      level_next = (diff_dn < cfg.fade_step) ? target_next : level - cfg.fade_step;
    end

    // the applied level always tracks the current level after the first step
    emit = !applied_valid || (level_next != level);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= lbf_pkg::LEVEL_ZERO;
      target        <= lbf_pkg::LEVEL_ZERO;
      applied_valid <= 1'b0;
    end else if (accept) begin
      level         <= level_next;
      target        <= target_next;
      applied_valid <= 1'b1;
    end
  end

endmodule

FILE: hdl/lbf_outbuf.sv
module lbf_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lbf_pkg::level_t  push_data,
  output logic             can_accept,
  output logic             out_valid,
  input  logic             out_ready,
  output lbf_pkg::level_t  duty
);

  logic            main_valid;
  lbf_pkg::level_t main_data;
  logic            skid_valid;
  lbf_pkg::level_t skid_data;
  logic            pop;

  assign pop        = main_valid && out_ready;
  assign can_accept = !skid_valid;
  assign out_valid  = main_valid;
  assign duty       = main_data;

  // push never arrives while the skid entry is full
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= push;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule
